// File: rtl/wmm_pkg.sv
// Package for the wildcard mask matcher: character codes, request and
// register codes, beat structs and small character helpers.
// No dependencies.
`timescale 1ns / 1ps

package wmm_pkg;

  // Default mask store depth
  localparam int unsigned MASK_LEN_DEF = 64;

  // Request types
  localparam logic REQ_MASK = 1'b0;
  localparam logic REQ_SUBJ = 1'b1;

  // Register index of the special-classes enable
  localparam logic REG_SPECIAL = 1'b0;

  // Mask metacharacters
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PCT   = 8'h25;

  // Character ranges
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Per-beat control broadcast to every cell
  typedef struct packed {
    logic       mask_beat;   // mask character accepted
    logic       subj_beat;   // subject character accepted
    logic       last;        // final character of mask or subject
    logic       start;       // mask beat that opens a new mask
    logic [7:0] ch;          // uppercased character
    logic       ch_star;     // character is a star
    logic       ch_digit;    // character is a digit
    logic       ch_alpha;    // character is a letter
    logic       special;     // class characters enabled
  } wmm_bcast_t;

  // Signals handed from one cell to the next
  typedef struct packed {
    logic used;   // slot holds a mask character
    logic wr;     // slot written on this beat
    logic init;   // position reached from the start by stars alone
    logic carry;  // star closure running on into the next position
    logic match;  // character matched, next position reached
  } wmm_link_t;

  function automatic logic [7:0] up_case(logic [7:0] c);
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      return c - CASE_OFS;
    end
    return c;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

endpackage

// File: rtl/wildcard_mask_matcher_unit.sv
// Top level of the wildcard mask matcher: cell chain, register port,
// output register. Depends on wmm_pkg and wmm_cell.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   req_type, char_code, last
// out      output     out_valid / out_stall matched, mask_truncated
// cfg      input      APB write/read        special_classes at address 0
//
// Characters are taken back to back while the input does not stall. The cycle
// time is set by the star closure rippling through the cell chain, one gate
// stage per mask slot. Results appear in the output register in the cycle
// after the subject's last beat. Input stalls only while a result sits there
// unclaimed. Reset leaves an empty mask, no result.

module wildcard_mask_matcher_unit
  import wmm_pkg::*;
#(
  parameter int unsigned MASK_LEN = MASK_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        matched_o,
  output logic        mask_truncated_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic special_q, special_d;
  logic open_q, open_d;
  logic ovf_q, ovf_d;
  logic tail_init_q, tail_init_d;
  logic tail_act_q, tail_act_d;
  logic out_valid_q, out_valid_d;
  logic matched_q, matched_d;
  logic trunc_q, trunc_d;

  logic          in_beat, tail_closed, result;
  logic [7:0]    uc;
  wmm_bcast_t    bc;
  wmm_link_t     lnk [MASK_LEN+1];
  logic [MASK_LEN-1:0] res_bits;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPECIAL) ? {31'd0, special_q} : 32'd0;
  assign special_d = (psel && penable && pwrite && paddr[2] == REG_SPECIAL)
                     ? pwdata[0] : special_q;

  // input beat and broadcast
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_beat    = in_valid_i & ~in_stall_o;
  assign uc         = up_case(char_code_i);

  assign bc.mask_beat = in_beat & (req_type_i == REQ_MASK);
  assign bc.subj_beat = in_beat & (req_type_i == REQ_SUBJ);
  assign bc.last      = last_i;
  assign bc.start     = ~open_q;
  assign bc.ch        = uc;
  assign bc.ch_star   = (uc == CH_STAR);
  assign bc.ch_digit  = is_digit(uc);
  assign bc.ch_alpha  = is_alpha(uc);
  assign bc.special   = special_q;

  // head of chain
  assign lnk[0].used  = 1'b1;
  assign lnk[0].wr    = 1'b0;
  assign lnk[0].init  = 1'b1;
  assign lnk[0].carry = 1'b0;
  assign lnk[0].match = 1'b0;

  // cell chain
  for (genvar i = 0; i < MASK_LEN; i++) begin : g_cell
    wmm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .head_i (i == 0),
      .bc_i   (bc),
      .lnk_i  (lnk[i]),
      .lnk_o  (lnk[i+1]),
      .res_o  (res_bits[i])
    );
  end

  // final position, reached only with a full store
  assign tail_closed = lnk[MASK_LEN].match | lnk[MASK_LEN].carry;
  assign result      = (|res_bits) | (tail_closed & lnk[MASK_LEN].used);

  always_comb begin
    tail_init_d = tail_init_q;
    tail_act_d  = tail_act_q;
    open_d      = open_q;
    ovf_d       = ovf_q;
    if (bc.mask_beat) begin
      if (lnk[MASK_LEN].wr) begin
        tail_init_d = lnk[MASK_LEN].init & bc.ch_star;
      end else if (bc.start) begin
        tail_init_d = 1'b0;
      end
      tail_act_d = tail_init_d;
      open_d     = ~last_i;
      if (bc.start) begin
        ovf_d = 1'b0;
      end else if (lnk[MASK_LEN].used) begin
        ovf_d = 1'b1;
      end
    end else if (bc.subj_beat) begin
      open_d     = 1'b0;
      tail_act_d = last_i ? tail_init_q : tail_closed;
    end
  end

  // output register
  assign out_valid_d = (out_valid_q & out_stall_i) | (bc.subj_beat & last_i);
  assign matched_d   = (bc.subj_beat & last_i) ? result : matched_q;
  assign trunc_d     = (bc.subj_beat & last_i) ? ovf_q : trunc_q;

  assign out_valid_o      = out_valid_q;
  assign matched_o        = matched_q;
  assign mask_truncated_o = trunc_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      special_q   <= 1'b0;
      open_q      <= 1'b0;
      ovf_q       <= 1'b0;
      tail_init_q <= 1'b0;
      tail_act_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      special_q   <= special_d;
      open_q      <= open_d;
      ovf_q       <= ovf_d;
      tail_init_q <= tail_init_d;
      tail_act_q  <= tail_act_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    trunc_q   <= trunc_d;
  end

endmodule

// File: rtl/wmm_cell.sv
// One cell of the matcher chain: a mask slot and its automaton position.
// Depends on wmm_pkg.
`timescale 1ns / 1ps

module wmm_cell
  import wmm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_i,
  input  wmm_bcast_t bc_i,
  input  wmm_link_t  lnk_i,
  output wmm_link_t  lnk_o,
  output logic       res_o
);

  logic [7:0] ch_q, ch_d;
  logic       used_q, used_d;
  logic       init_q, init_d;
  logic       act_q, act_d;

  logic is_star, at_len, wr, ok;
  logic keep, hit, raw, closed;

  assign is_star = (ch_q == CH_STAR);
  // position equals mask length
  assign at_len  = lnk_i.used & ~used_q;

  // slot write: first slot on a new mask, else the slot just past the end
  assign wr = bc_i.mask_beat & (bc_i.start ? head_i : at_len);

  // character test against this slot
  always_comb begin
    ok = (ch_q == CH_QMARK) || (ch_q == bc_i.ch);
    if (bc_i.special) begin
      if (ch_q == CH_HASH && bc_i.ch_digit) ok = 1'b1;
      if (ch_q == CH_AMP && bc_i.ch_alpha) ok = 1'b1;
      if (ch_q == CH_PCT && (bc_i.ch_alpha || bc_i.ch_digit)) ok = 1'b1;
    end
  end

  // step and star closure; closure ripples like a carry chain
  assign keep   = act_q & used_q & is_star;
  assign hit    = act_q & used_q & ~is_star & ok;
  assign raw    = keep | lnk_i.match;
  assign closed = raw | lnk_i.carry;

  assign res_o = closed & at_len;

  assign lnk_o.used  = used_q;
  assign lnk_o.wr    = wr;
  assign lnk_o.init  = init_q;
  assign lnk_o.carry = closed & used_q & is_star;
  assign lnk_o.match = hit;

  // next state
  always_comb begin
    ch_d   = wr ? bc_i.ch : ch_q;
    used_d = used_q;
    init_d = init_q;
    act_d  = act_q;
    if (bc_i.mask_beat) begin
      used_d = bc_i.start ? head_i : (used_q | wr);
      if (head_i) begin
        init_d = 1'b1;
      end else if (lnk_i.wr) begin
        init_d = lnk_i.init & bc_i.ch_star;
      end else if (bc_i.start) begin
        init_d = 1'b0;
      end
      act_d = init_d;
    end else if (bc_i.subj_beat) begin
      act_d = bc_i.last ? init_q : closed;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      init_q <= head_i;
      act_q  <= head_i;
    end else begin
      used_q <= used_d;
      init_q <= init_d;
      act_q  <= act_d;
    end
  end

  // mask character, no reset
  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
  end

endmodule

// File: dv/testbench.sv
// Self-checking bench for wildcard_mask_matcher_unit: directed and random mask and
// subject beats, an in-bench position-automaton predictor and a verdict scoreboard.
// Depends on wmm_pkg and the matcher RTL only.
`timescale 1ns / 1ps

module testbench;
  import wmm_pkg::*;

  // Predicts verdicts from accepted beats and checks each result against them
  class match_scoreboard;
    localparam int unsigned SLOTS = MASK_LEN_DEF;

    bit              special;
    bit [7:0]        mask_chars[SLOTS];
    int unsigned     mask_len;
    bit [SLOTS:0]    live;
    bit              loading;
    bit              dropped;
    bit [1:0]        verdicts_due[$];   // {matched, truncated}
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     hits;
    int unsigned     truncs;

    function new();
      live = '0;
      live[0] = 1'b1;
    endfunction

    // one line per mismatch
    task report(string what);
      $display("mismatch @%0t: %s", $time, what);
      errors++;
    endtask

    // follow runs of '*' onto the position after them
    function bit [SLOTS:0] close_stars(bit [SLOTS:0] set);
      int unsigned i;
      for (i = 0; i < mask_len; i++) begin
        if (set[i] && mask_chars[i] == CH_STAR) set[i+1] = 1'b1;
      end
      return set;
    endfunction

    // advance the automaton by one accepted beat
    function void note_beat(bit req, bit [7:0] code, bit last);
      bit [7:0]     c;
      bit [7:0]     m;
      bit [SLOTS:0] cur;
      bit [SLOTS:0] nxt;
      bit           dig;
      bit           alp;
      bit           ok;
      int unsigned  i;
      c = code;
      if (c >= CH_LO_A && c <= CH_LO_Z) c = c - CASE_OFS;
      if (req == REQ_MASK) begin
        if (!loading) begin
          mask_len = 0;
          dropped  = 1'b0;
          loading  = 1'b1;
        end
        if (mask_len < SLOTS) begin
          mask_chars[mask_len] = c;
          mask_len++;
        end else begin
          dropped = 1'b1;
        end
        if (last) loading = 1'b0;
        live = '0;
        live[0] = 1'b1;
        return;
      end
      // subject beat: any open mask is closed
      loading = 1'b0;
      dig = (c >= CH_D0) && (c <= CH_D9);
      alp = (c >= CH_UP_A) && (c <= CH_UP_Z);
      cur = close_stars(live);
      nxt = '0;
      for (i = 0; i < mask_len; i++) begin
        if (cur[i]) begin
          m = mask_chars[i];
          ok = (m == CH_QMARK) || (c == m) ||
               (special && ((m == CH_HASH && dig) || (m == CH_AMP && alp) ||
                            (m == CH_PCT && (alp || dig))));
          if (m == CH_STAR) nxt[i] = 1'b1;
          else if (ok) nxt[i+1] = 1'b1;
        end
      end
      if (!last) begin
        live = nxt;
        return;
      end
      nxt = close_stars(nxt);
      verdicts_due.push_back({nxt[mask_len], dropped});
      live = '0;
      live[0] = 1'b1;
    endfunction

    task check_verdict(logic matched, logic truncated);
      bit [1:0] want;
      checked++;
      if (matched === 1'b1) hits++;
      if (truncated === 1'b1) truncs++;
      if (verdicts_due.size() == 0) begin
        report("result beat with no verdict pending");
      end else begin
        want = verdicts_due.pop_front();
        if (matched !== want[1])
          report($sformatf("matched %b, expected %b", matched, want[1]));
        if (truncated !== want[0])
          report($sformatf("mask_truncated %b, expected %b", truncated, want[0]));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = REQ_MASK;
  logic [7:0]  char_code_i = 8'h00;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        matched_o;
  logic        mask_truncated_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  match_scoreboard sb;
  int unsigned     beats_sent;
  bit              calm;   // no idling on either side while set

  wildcard_mask_matcher_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .char_code_i      (char_code_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_o        (matched_o),
    .mask_truncated_o (mask_truncated_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk_i = ~clk_i;

  // one input beat, after a random gap, held until taken
  task automatic send_beat(bit req, bit [7:0] code, bit last);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    char_code_i <= code;
    last_i      <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(req, code, last);
    beats_sent++;
  endtask

  task automatic send_chars(bit req, string s, bit close);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(req, s[i], close && (i == s.len() - 1));
  endtask

  // drain all pending verdicts, then let the pipe run idle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write followed by a read-back
  task automatic set_special(bit v);
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_SPECIAL);
    pwdata  <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.special = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== v) sb.report($sformatf("special_classes read back %b, wrote %b", rd[0], v));
  endtask

  // short letters, digits, now and then any byte
  function automatic bit [7:0] pick_filler();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return (CH_LO_A + 8'($urandom_range(0, 4))) ^ (r[0] ? CASE_OFS : 8'h00);
    if (r < 8) return CH_D0 + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  // result side: random stall per result, then take it
  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_verdict(matched_o, mask_truncated_o);
    end
  end

  initial begin : stimulus
    bit [7:0]    pat[$];
    bit [7:0]    subj[$];
    bit [7:0]    p;
    bit          phase_special[6];
    bit          close;
    int unsigned len;
    int unsigned kept;
    int unsigned roll;
    int unsigned target;
    int unsigned n;
    int unsigned ph;
    int unsigned i;
    int unsigned k;
    phase_special = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, classes on
    set_special(1'b1);
    send_chars(REQ_SUBJ, "a", 1'b1);          // nothing loaded yet
    send_chars(REQ_MASK, "a?#", 1'b1);
    send_chars(REQ_SUBJ, "Az7", 1'b1);
    send_chars(REQ_SUBJ, "bq", 1'b0);         // abandoned by the next mask
    send_chars(REQ_MASK, "*", 1'b1);          // stars only
    send_beat(REQ_SUBJ, 8'hFF, 1'b1);
    send_chars(REQ_MASK, "&%", 1'b0);         // closed by the subject
    send_chars(REQ_SUBJ, "x9", 1'b1);
    send_beat(REQ_MASK, 8'h80, 1'b1);
    send_beat(REQ_SUBJ, 8'h80, 1'b1);
    send_beat(REQ_SUBJ, 8'h00, 1'b1);
    send_beat(REQ_MASK, 8'h00, 1'b1);
    send_beat(REQ_SUBJ, 8'h00, 1'b1);
    send_chars(REQ_MASK, "z", 1'b1);
    send_chars(REQ_SUBJ, "Z", 1'b1);
    send_chars(REQ_SUBJ, "A", 1'b1);

    // random phases, register changed between them
    for (ph = 0; ph < 6; ph++) begin
      settle();
      set_special(phase_special[ph]);
      target = beats_sent + 260;
      while (beats_sent < target) begin
        roll = $urandom_range(0, 99);
        calm = ($urandom_range(0, 4) == 0);
        if (roll < 10) begin
          // noise: anything at all
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++)
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end else if (roll < 15) begin
          // subject cut short; the next mask drops it
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) send_beat(REQ_SUBJ, pick_filler(), 1'b0);
        end else begin
          // mask, sometimes past capacity
          len = ($urandom_range(0, 99) < 4) ? $urandom_range(62, 70) : $urandom_range(1, 8);
          close = ($urandom_range(0, 4) != 0);
          pat.delete();
          for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 13))
              0, 1, 2, 3: p = CH_STAR;
              4:          p = CH_QMARK;
              5:          p = CH_HASH;
              6:          p = CH_AMP;
              7:          p = CH_PCT;
              12:         p = ($urandom_range(0, 1) ? CH_LO_Z : CH_LO_A) ^
                              ($urandom_range(0, 1) ? CASE_OFS : 8'h00);
              13:         p = 8'($urandom_range(0, 255));
              default:    p = pick_filler();
            endcase
            pat.push_back(p);
            send_beat(REQ_MASK, p, close && (i == len - 1));
          end
          kept = (len > MASK_LEN_DEF) ? MASK_LEN_DEF : len;
          // subjects: mostly built to match, some spoiled or random
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            subj.delete();
            if ($urandom_range(0, 9) < 7) begin
              for (i = 0; i < kept; i++) begin
                p = pat[i];
                if (p == CH_STAR) begin
                  repeat ($urandom_range(0, 3)) subj.push_back(pick_filler());
                end else if (p == CH_QMARK) begin
                  subj.push_back(pick_filler());
                end else if (p == CH_HASH && sb.special) begin
                  subj.push_back(CH_D0 + 8'($urandom_range(0, 9)));
                end else if (p == CH_AMP && sb.special) begin
                  subj.push_back((CH_UP_A + 8'($urandom_range(0, 25))) ^
                                 ($urandom_range(0, 1) ? CASE_OFS : 8'h00));
                end else if (p == CH_PCT && sb.special) begin
                  subj.push_back($urandom_range(0, 1) ? CH_D0 + 8'($urandom_range(0, 9))
                                                      : CH_UP_A + 8'($urandom_range(0, 25)));
                end else if ((p >= CH_LO_A && p <= CH_LO_Z) ||
                             (p >= CH_UP_A && p <= CH_UP_Z)) begin
                  subj.push_back(p ^ ($urandom_range(0, 1) ? CASE_OFS : 8'h00));
                end else begin
                  subj.push_back(p);
                end
              end
              if (subj.size() != 0 && $urandom_range(0, 4) == 0)
                subj[$urandom_range(0, subj.size() - 1)] = pick_filler();
            end else begin
              repeat ($urandom_range(1, 10)) subj.push_back(pick_filler());
            end
            if (subj.size() == 0) subj.push_back(pick_filler());
            for (i = 0; i < subj.size(); i++)
              send_beat(REQ_SUBJ, subj[i], i == subj.size() - 1);
          end
        end
      end
      calm = 1'b0;
    end

    settle();
    $display("ran %0d input beats over both class settings, %0d verdicts checked",
             beats_sent, sb.checked);
    $display("of those %0d matched and %0d came from truncated masks", sb.hits, sb.truncs);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("wildcard_mask_matcher_unit regression: pass");
    end else begin
      $display("wildcard_mask_matcher_unit regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("wildcard_mask_matcher_unit regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/wmm_pkg.sv
rtl/wmm_cell.sv
rtl/wildcard_mask_matcher_unit.sv
dv/testbench.sv
